// ===== rtl/frs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the flash request scheduler: sizes, item codes and item types.
// Used by frs_queues and flash_request_scheduler; depends on nothing.
package frs_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int PAGE_BYTES  = 1024;
	localparam int PAGE_COUNT  = 256;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_ERASE = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_STORE_PAGE = 2'd0,
		CFG_REC_FIRST  = 2'd1,
		CFG_REC_LAST   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] store_page;
		logic [7:0] rec_first_page;
		logic [7:0] rec_last_page;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  erase_page;
		logic [17:0] write_addr;
		logic [10:0] write_len;
		logic        issue_accepted;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        issue_valid;
		logic        issue_is_write;
		logic [7:0]  issue_page;
		logic [17:0] issue_addr;
		logic [8:0]  issue_words;
		logic [1:0]  erase_pending;
		logic [1:0]  write_pending;
	} rsp_t;

endpackage

// ===== rtl/frs_queues.sv =====
`timescale 1ns / 1ps
// Erase and write request queues with their outstanding flags and the
// per-item decision logic. Depends on frs_pkg.
module frs_queues (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  frs_pkg::req_t req_s1,
	input  frs_pkg::cfg_t cfg,
	output frs_pkg::rsp_t rsp_d
);

	logic [7:0]  erase_q      [frs_pkg::QUEUE_DEPTH];
	logic [17:0] waddr_q      [frs_pkg::QUEUE_DEPTH];
	logic [10:0] wlen_q       [frs_pkg::QUEUE_DEPTH];
	logic [7:0]  erase_d      [frs_pkg::QUEUE_DEPTH];
	logic [17:0] waddr_d      [frs_pkg::QUEUE_DEPTH];
	logic [10:0] wlen_d       [frs_pkg::QUEUE_DEPTH];
	logic [frs_pkg::CNT_W-1:0] ecount_q, ecount_d, wcount_q, wcount_d;
	logic        eout_q, eout_d, wout_q, wout_d;

	logic [17:0] wpage_full;
	logic [7:0]  req_page;
	logic        page_ok;
	logic        idle;

	always_comb begin
		wpage_full = req_s1.write_addr >> frs_pkg::PAGE_SHIFT;
		wpage_full = wpage_full & 18'(frs_pkg::PAGE_COUNT - 1);
		if (req_s1.kind == frs_pkg::KIND_ERASE) begin
			req_page = req_s1.erase_page;
		end else begin
			req_page = wpage_full[7:0];
		end
		page_ok = (req_page == cfg.store_page) ||
			((req_page >= cfg.rec_first_page) && (req_page <= cfg.rec_last_page));
		idle = !eout_q && !wout_q;
	end

	always_comb begin
		erase_d  = erase_q;
		waddr_d  = waddr_q;
		wlen_d   = wlen_q;
		ecount_d = ecount_q;
		wcount_d = wcount_q;
		eout_d   = eout_q;
		wout_d   = wout_q;
		rsp_d    = '0;
		rsp_d.status = frs_pkg::ST_OK;
		case (frs_pkg::kind_t'(req_s1.kind))
			frs_pkg::KIND_ERASE: begin
				if (!page_ok) begin
					rsp_d.status = frs_pkg::ST_RANGE;
				end else if (ecount_q >= frs_pkg::CNT_W'(frs_pkg::QUEUE_DEPTH)) begin
					rsp_d.status = frs_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < frs_pkg::QUEUE_DEPTH; i++) begin
						if (frs_pkg::CNT_W'(i) == ecount_q) begin
							erase_d[i] = req_s1.erase_page;
						end
					end
					ecount_d = ecount_q + 1'b1;
				end
			end
			frs_pkg::KIND_WRITE: begin
				if (!page_ok) begin
					rsp_d.status = frs_pkg::ST_RANGE;
				end else if (wcount_q >= frs_pkg::CNT_W'(frs_pkg::QUEUE_DEPTH)) begin
					rsp_d.status = frs_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < frs_pkg::QUEUE_DEPTH; i++) begin
						if (frs_pkg::CNT_W'(i) == wcount_q) begin
							waddr_d[i] = req_s1.write_addr;
							wlen_d[i]  = req_s1.write_len;
						end
					end
					wcount_d = wcount_q + 1'b1;
				end
			end
			frs_pkg::KIND_TICK: begin
				if (idle && (ecount_q != '0)) begin
					rsp_d.issue_valid = 1'b1;
					rsp_d.issue_page  = erase_q[0];
					if (req_s1.issue_accepted) begin
						eout_d = 1'b1;
					end
				end else if (idle && (wcount_q != '0)) begin
					rsp_d.issue_valid    = 1'b1;
					rsp_d.issue_is_write = 1'b1;
					rsp_d.issue_addr     = waddr_q[0];
					rsp_d.issue_words    = wlen_q[0][10:2];
					if (req_s1.issue_accepted) begin
						wout_d = 1'b1;
					end
				end
			end
			frs_pkg::KIND_DONE: begin
				if (eout_q) begin
					eout_d = 1'b0;
					for (int i = 0; i < frs_pkg::QUEUE_DEPTH - 1; i++) begin
						erase_d[i] = erase_q[i + 1];
					end
					erase_d[frs_pkg::QUEUE_DEPTH - 1] = '0;
					if (ecount_q != '0) begin
						ecount_d = ecount_q - 1'b1;
					end
				end else if (wout_q) begin
					wout_d = 1'b0;
					for (int i = 0; i < frs_pkg::QUEUE_DEPTH - 1; i++) begin
						waddr_d[i] = waddr_q[i + 1];
						wlen_d[i]  = wlen_q[i + 1];
					end
					waddr_d[frs_pkg::QUEUE_DEPTH - 1] = '0;
					wlen_d[frs_pkg::QUEUE_DEPTH - 1]  = '0;
					if (wcount_q != '0) begin
						wcount_d = wcount_q - 1'b1;
					end
				end
			end
			default: begin
				rsp_d.status = frs_pkg::ST_OK;
			end
		endcase
		rsp_d.erase_pending = 2'(ecount_d);
		rsp_d.write_pending = 2'(wcount_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q <= '0;
			wcount_q <= '0;
			eout_q   <= 1'b0;
			wout_q   <= 1'b0;
			for (int i = 0; i < frs_pkg::QUEUE_DEPTH; i++) begin
				erase_q[i] <= '0;
				waddr_q[i] <= '0;
				wlen_q[i]  <= '0;
			end
		end else if (valid_s1) begin
			ecount_q <= ecount_d;
			wcount_q <= wcount_d;
			eout_q   <= eout_d;
			wout_q   <= wout_d;
			erase_q  <= erase_d;
			waddr_q  <= waddr_d;
			wlen_q   <= wlen_d;
		end
	end

endmodule

// ===== rtl/flash_request_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the flash request scheduler: configuration registers, input
// register, queue logic and result register. Depends on frs_pkg, frs_queues.

// An item is taken on every cycle with start high; busy is always low. Each
// item gives one result on rsp, with done high for that one cycle, after it
// passes into the input register and then through the queue logic into the
// result register. The receiver cannot stall, so results must be captured in
// the cycle they appear.
module flash_request_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  frs_pkg::req_t req,
	output logic          busy,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [7:0]    cfg_wdata,
	output logic          done,
	output frs_pkg::rsp_t rsp
);

	frs_pkg::cfg_t cfg_q;
	frs_pkg::req_t req_s1;
	frs_pkg::rsp_t rsp_d;
	frs_pkg::rsp_t rsp_q;
	logic          valid_s1;
	logic          done_q;

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.store_page     <= 8'd0;
			cfg_q.rec_first_page <= 8'd255;
			cfg_q.rec_last_page  <= 8'd0;
		end else if (cfg_we) begin
			case (frs_pkg::cfg_idx_t'(cfg_idx))
				frs_pkg::CFG_STORE_PAGE: cfg_q.store_page     <= cfg_wdata;
				frs_pkg::CFG_REC_FIRST:  cfg_q.rec_first_page <= cfg_wdata;
				frs_pkg::CFG_REC_LAST:   cfg_q.rec_last_page  <= cfg_wdata;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	frs_queues u_queues (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.cfg      (cfg_q),
		.rsp_d    (rsp_d)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flash_request_scheduler: a directed table, then random
// phases under several range settings, each result checked against a local scheduler copy
// or the table's expected value. Depends on frs_pkg and the flash_request_scheduler RTL.
module tb;
	import frs_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 275;
	localparam int PHASE_COUNT    = 6;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	req_t       req;
	logic       busy;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_wdata;
	logic       done;
	rsp_t       rsp;

	cfg_t        cfg_now;
	logic [7:0]  erase_q [QUEUE_DEPTH];
	logic [1:0]  erase_cnt;
	bit          erase_out;
	logic [17:0] waddr_q [QUEUE_DEPTH];
	logic [10:0] wlen_q [QUEUE_DEPTH];
	logic [1:0]  write_cnt;
	bit          write_out;

	rsp_t     outcome_q[$];
	rsp_t     head_rsp;
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       idle_cycles = 0;

	flash_request_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic bit page_ok(logic [7:0] page);
		return page == cfg_now.store_page ||
			(page >= cfg_now.rec_first_page && page <= cfg_now.rec_last_page);
	endfunction

	function automatic rsp_t schedule_outcome(req_t r);
		rsp_t       o;
		logic [7:0] wpage;
		int         i;
		o = '0;
		wpage = r.write_addr >> PAGE_SHIFT;
		case (kind_t'(r.kind))
			KIND_ERASE: begin
				if (!page_ok(r.erase_page)) begin
					o.status = ST_RANGE;
				end else if (erase_cnt >= QUEUE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					erase_q[erase_cnt] = r.erase_page;
					erase_cnt = erase_cnt + 1;
				end
			end
			KIND_WRITE: begin
				if (!page_ok(wpage)) begin
					o.status = ST_RANGE;
				end else if (write_cnt >= QUEUE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					waddr_q[write_cnt] = r.write_addr;
					wlen_q[write_cnt] = r.write_len;
					write_cnt = write_cnt + 1;
				end
			end
			KIND_TICK: begin
				if (!erase_out && !write_out && erase_cnt != 0) begin
					o.issue_valid = 1'b1;
					o.issue_page = erase_q[0];
					if (r.issue_accepted)
						erase_out = 1'b1;
				end else if (!erase_out && !write_out && write_cnt != 0) begin
					o.issue_valid = 1'b1;
					o.issue_is_write = 1'b1;
					o.issue_addr = waddr_q[0];
					o.issue_words = wlen_q[0] >> 2;
					if (r.issue_accepted)
						write_out = 1'b1;
				end
			end
			default: begin
				if (erase_out) begin
					erase_out = 1'b0;
					for (i = 0; i + 1 < QUEUE_DEPTH; i++)
						erase_q[i] = erase_q[i + 1];
					erase_q[QUEUE_DEPTH - 1] = '0;
					if (erase_cnt != 0)
						erase_cnt = erase_cnt - 1;
				end else if (write_out) begin
					write_out = 1'b0;
					for (i = 0; i + 1 < QUEUE_DEPTH; i++) begin
						waddr_q[i] = waddr_q[i + 1];
						wlen_q[i] = wlen_q[i + 1];
					end
					waddr_q[QUEUE_DEPTH - 1] = '0;
					wlen_q[QUEUE_DEPTH - 1] = '0;
					if (write_cnt != 0)
						write_cnt = write_cnt - 1;
				end
			end
		endcase
		o.erase_pending = erase_cnt;
		o.write_pending = write_cnt;
		return o;
	endfunction

	function automatic req_t random_item();
		req_t       r;
		logic [7:0] page;
		int         pick;
		r.kind = $urandom;
		r.erase_page = $urandom;
		r.write_addr = $urandom;
		r.write_len = ($urandom_range(0, 15) == 0) ? 11'd1024 : $urandom_range(0, 1023);
		r.issue_accepted = $urandom;
		if ($urandom_range(0, 9) < 8) begin
			if (cfg_now.rec_first_page <= cfg_now.rec_last_page && $urandom_range(0, 3) != 0)
				page = $urandom_range(cfg_now.rec_last_page, cfg_now.rec_first_page);
			else
				page = cfg_now.store_page;
		end else begin
			page = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			r.kind = KIND_ERASE;
			r.erase_page = page;
		end else if (pick < 50) begin
			r.kind = KIND_WRITE;
			r.write_addr[17:PAGE_SHIFT] = page;
		end else if (pick < 80) begin
			r.kind = KIND_TICK;
			r.issue_accepted = ($urandom_range(0, 9) < 8);
		end else begin
			r.kind = KIND_DONE;
		end
		return r;
	endfunction

	task automatic add_row(kind_t k, logic [7:0] page, logic [17:0] addr, logic [10:0] len,
			bit acc, bit typed, status_t st, logic [1:0] ep, logic [1:0] wp);
		dir_row_t row;
		row.item.kind = k;
		row.item.erase_page = page;
		row.item.write_addr = addr;
		row.item.write_len = len;
		row.item.issue_accepted = acc;
		row.typed = typed;
		row.want = '0;
		row.want.status = st;
		row.want.erase_pending = ep;
		row.want.write_pending = wp;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(req_t r, int idle_pct, bit typed, rsp_t want);
		rsp_t o;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		o = schedule_outcome(r);
		outcome_q.push_back(typed ? want : o);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(cfg_t c);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_STORE_PAGE;
		cfg_wdata <= c.store_page;
		@(posedge clk);
		cfg_idx <= CFG_REC_FIRST;
		cfg_wdata <= c.rec_first_page;
		@(posedge clk);
		cfg_idx <= CFG_REC_LAST;
		cfg_wdata <= c.rec_last_page;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result with no item waiting, expected none, got %p", $time, rsp);
				errors++;
			end else begin
				head_rsp = outcome_q.pop_front();
				check_field("status", head_rsp.status, rsp.status);
				check_field("issue_valid", head_rsp.issue_valid, rsp.issue_valid);
				check_field("issue_is_write", head_rsp.issue_is_write, rsp.issue_is_write);
				check_field("issue_page", head_rsp.issue_page, rsp.issue_page);
				check_field("issue_addr", head_rsp.issue_addr, rsp.issue_addr);
				check_field("issue_words", head_rsp.issue_words, rsp.issue_words);
				check_field("erase_pending", head_rsp.erase_pending, rsp.erase_pending);
				check_field("write_pending", head_rsp.write_pending, rsp.write_pending);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		cfg_t       c;
		logic [7:0] a;
		logic [7:0] b;
		int         p;
		int         n;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_STORE_PAGE;
		cfg_wdata <= '0;
		cfg_now = {8'h00, 8'hFF, 8'h00};
		for (n = 0; n < QUEUE_DEPTH; n++) begin
			erase_q[n] = '0;
			waddr_q[n] = '0;
			wlen_q[n] = '0;
		end
		erase_cnt = '0;
		write_cnt = '0;
		erase_out = 1'b0;
		write_out = 1'b0;

		add_row(KIND_ERASE, 8'h00, 18'h3FFFF, 11'd1024, 1'b1, 1, ST_OK, 2'd1, 2'd0);
		add_row(KIND_ERASE, 8'hFF, 18'h00000, 11'd0, 1'b0, 1, ST_RANGE, 2'd1, 2'd0);
		add_row(KIND_WRITE, 8'h00, 18'h3FFFF, 11'd1024, 1'b0, 1, ST_RANGE, 2'd1, 2'd0);
		add_row(KIND_WRITE, 8'hFF, 18'h003FC, 11'd1024, 1'b1, 1, ST_OK, 2'd1, 2'd1);
		add_row(KIND_ERASE, 8'h00, 18'h00000, 11'd0, 1'b0, 1, ST_OK, 2'd2, 2'd1);
		add_row(KIND_ERASE, 8'h00, 18'h00000, 11'd0, 1'b0, 1, ST_FULL, 2'd2, 2'd1);
		add_row(KIND_WRITE, 8'h00, 18'h00001, 11'd3, 1'b0, 1, ST_OK, 2'd2, 2'd2);
		add_row(KIND_WRITE, 8'h00, 18'h3FFFF, 11'd7, 1'b0, 1, ST_RANGE, 2'd2, 2'd2);
		add_row(KIND_WRITE, 8'h00, 18'h00000, 11'd4, 1'b0, 1, ST_FULL, 2'd2, 2'd2);
		add_row(KIND_DONE, 8'hFF, 18'h3FFFF, 11'd1024, 1'b1, 1, ST_OK, 2'd2, 2'd2);
		add_row(KIND_TICK, 8'hFF, 18'h3FFFF, 11'd1024, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_ERASE, 8'h00, 18'h00000, 11'd0, 1'b0, 1, ST_FULL, 2'd2, 2'd2);
		add_row(KIND_DONE, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_DONE, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_ERASE, 8'h00, 18'h3FFFF, 11'd1024, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_DONE, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_DONE, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_TICK, 8'h00, 18'h00000, 11'd0, 1'b1, 0, ST_OK, 2'd0, 2'd0);
		add_row(KIND_DONE, 8'h00, 18'h00000, 11'd0, 1'b0, 0, ST_OK, 2'd0, 2'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_config({8'h00, 8'hFF, 8'h00});
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, 31, dir_rows[i].typed, dir_rows[i].want);
		settle();

		for (p = 0; p < PHASE_COUNT; p++) begin
			a = $urandom;
			b = $urandom;
			case (p)
				0: c = {8'hFF, 8'h00, 8'hFF};
				1: c = {8'h00, 8'hFF, 8'h00};
				2: c = {a, b, b};
				3: c = {a, b, 8'(b + $urandom_range(0, 15))};
				4: c = {8'h80, 8'h80, 8'h7F};
				default: c = {a, b, 8'($urandom)};
			endcase
			write_config(c);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), (p % 3 == 0) ? 31 : ((p % 3 == 1) ? 76 : 0), 0, '0);
			settle();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== flash_request_scheduler.f =====
rtl/frs_pkg.sv
rtl/frs_queues.sv
rtl/flash_request_scheduler.sv
tb/sv/tb.sv
